FILE: hw/rtl/dtse_pkg.sv
`timescale 1ns / 1ps

package dtse_pkg;

    // Command codes carried on the command field.
    localparam logic [2:0] CMD_BOOL = 3'd0;
    localparam logic [2:0] CMD_UINT = 3'd1;
    localparam logic [2:0] CMD_SINT = 3'd2;
    localparam logic [2:0] CMD_NULL = 3'd3;
    localparam logic [2:0] CMD_HDR  = 3'd4;
    localparam logic [2:0] CMD_BYTE = 3'd5;

    // Error codes carried on the error field.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_LIMIT      = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

    // Microprogram step addresses.
    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_DISPATCH = 4'd1,
        ST_SIZE     = 4'd2,
        ST_CHECK    = 4'd3,
        ST_IDENT    = 4'd4,
        ST_LEN      = 4'd5,
        ST_SKIP     = 4'd6,
        ST_CONT     = 4'd7,
        ST_ERR      = 4'd8,
        ST_BYTE     = 4'd9
    } step_t;

    // Source of the byte put out by an emitting step.
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_IDENT,
        SRC_LEN,
        SRC_CONT,
        SRC_ERR,
        SRC_CBYTE
    } src_t;

    // Jump conditions tested by the sequencer.
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_ACCEPT,
        C_CMD_BYTE,
        C_CMD_BAD,
        C_FAIL,
        C_DONE,
        C_EMPTY
    } cond_t;

    // One microinstruction.
    typedef struct packed {
        logic  take;     // input channel open
        logic  size;     // register the size calculation
        logic  check;    // limit check and commit of the counters
        logic  emit;     // step puts bytes out
        src_t  src;
        cond_t cond;
        step_t jump;     // target when the condition holds
        logic  advance;  // otherwise go to the next step, else stay
    } ucode_t;

    // Status returned by the datapath to the sequencer.
    typedef struct packed {
        logic accept;
        logic cmd_byte;
        logic cmd_bad;
        logic fail;
        logic done;
        logic empty;
    } status_t;

    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        w = '{take: 1'b0, size: 1'b0, check: 1'b0, emit: 1'b0, src: SRC_NONE,
              cond: C_NEVER, jump: ST_IDLE, advance: 1'b0};
        case (step)
            ST_IDLE:
            begin
                w.take = 1'b1;
                w.cond = C_ACCEPT;
                w.jump = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                w.cond    = C_CMD_BYTE;
                w.jump    = ST_BYTE;
                w.advance = 1'b1;
            end
            ST_SIZE:
            begin
                w.size    = 1'b1;
                w.cond    = C_CMD_BAD;
                w.jump    = ST_IDLE;
                w.advance = 1'b1;
            end
            ST_CHECK:
            begin
                w.check   = 1'b1;
                w.cond    = C_FAIL;
                w.jump    = ST_ERR;
                w.advance = 1'b1;
            end
            ST_IDENT:
            begin
                w.emit = 1'b1;
                w.src  = SRC_IDENT;
                w.cond = C_DONE;
                w.jump = ST_LEN;
            end
            ST_LEN:
            begin
                w.emit = 1'b1;
                w.src  = SRC_LEN;
                w.cond = C_DONE;
                w.jump = ST_SKIP;
            end
            ST_SKIP:
            begin
                w.cond    = C_EMPTY;
                w.jump    = ST_IDLE;
                w.advance = 1'b1;
            end
            ST_CONT:
            begin
                w.emit = 1'b1;
                w.src  = SRC_CONT;
                w.cond = C_DONE;
                w.jump = ST_IDLE;
            end
            ST_ERR:
            begin
                w.emit = 1'b1;
                w.src  = SRC_ERR;
                w.cond = C_DONE;
                w.jump = ST_IDLE;
            end
            ST_BYTE:
            begin
                w.emit = 1'b1;
                w.src  = SRC_CBYTE;
                w.cond = C_DONE;
                w.jump = ST_IDLE;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.jump = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hw/rtl/dtse_sequencer.sv
`timescale 1ns / 1ps

module dtse_sequencer import dtse_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  status_t stat,
    output ucode_t  word
);

    step_t step_reg;
    step_t step_next;
    logic  hit;

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        case (word.cond)
            C_NEVER:    hit = 1'b0;
            C_ALWAYS:   hit = 1'b1;
            C_ACCEPT:   hit = stat.accept;
            C_CMD_BYTE: hit = stat.cmd_byte;
            C_CMD_BAD:  hit = stat.cmd_bad;
            C_FAIL:     hit = stat.fail;
            C_DONE:     hit = stat.done;
            C_EMPTY:    hit = stat.empty;
            default:    hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (hit)
        begin
            step_next = word.jump;
        end
        else if (word.advance)
        begin
            step_next = step_t'(step_reg + 4'd1);
        end
        else
        begin
            step_next = step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: hw/rtl/dtse_datapath.sv
`timescale 1ns / 1ps

module dtse_datapath import dtse_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  ucode_t      word,
    output status_t     stat,
    input  logic        in_valid,
    input  logic [2:0]  command,
    input  logic [1:0]  id_class,
    input  logic        constructed,
    input  logic [63:0] tag_number,
    input  logic [63:0] value,
    input  logic [31:0] content_length,
    input  logic [7:0]  content_byte,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    input  logic        out_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [1:0]  error
);

    // Latched item.
    logic [2:0]  cmd_reg;
    logic [1:0]  cls_reg;
    logic        cons_reg;
    logic [63:0] tag_reg;
    logic [63:0] val_reg;
    logic [31:0] clen_reg;
    logic [7:0]  cbyte_reg;

    // Sizes of the encoding.
    logic [7:0]  id_first_reg,   id_first_next;
    logic [3:0]  id_groups_reg,  id_groups_next;
    logic [3:0]  id_len_reg,     id_len_next;
    logic [31:0] len_val_reg,    len_val_next;
    logic        len_short_reg,  len_short_next;
    logic [2:0]  len_n_reg,      len_n_next;
    logic [2:0]  len_len_reg,    len_len_next;
    logic [3:0]  cont_len_reg,   cont_len_next;
    logic [71:0] cont_word_reg,  cont_word_next;
    logic [32:0] add_reg,        add_next;

    // Counters and limit.
    logic [31:0] lim_reg,        lim_next;
    logic [31:0] written_reg,    written_next;
    logic [31:0] pending_reg,    pending_next;
    logic [3:0]  idx_reg,        idx_next;

    // Output register.
    logic        out_valid_reg,  out_valid_next;
    logic [7:0]  out_byte_reg,   out_byte_next;
    logic        last_reg,       last_next;
    logic [1:0]  error_reg,      error_next;

    logic        accept;
    logic        is_hdr;
    logic        is_null;
    logic        out_load;
    logic [3:0]  phase_len;
    logic        fail;
    logic [7:0]  sel_byte;
    logic        sel_last;
    logic [1:0]  sel_err;

    logic [69:0] tag_ext;
    logic [6:0]  grp [10];
    logic [7:0]  lbyte [4];
    logic [7:0]  cbyte_w [9];
    logic [3:0]  gi;
    logic [1:0]  bi;
    logic [3:0]  ci;

    assign accept  = word.take & in_valid;
    assign is_hdr  = (cmd_reg == CMD_HDR);
    assign is_null = (cmd_reg == CMD_NULL);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            cls_reg   <= id_class;
            cons_reg  <= constructed;
            tag_reg   <= tag_number;
            val_reg   <= value;
            clen_reg  <= content_length;
            cbyte_reg <= content_byte;
        end
    end

    // Size calculation: priority searches over the fixed byte and group positions.
    always_comb
    begin
        logic        tshort;
        logic [3:0]  groups;
        logic [3:0]  un;
        logic        lead;
        logic [3:0]  sn;
        logic [63:0] sh;
        logic [3:0]  clen;
        logic [71:0] cword;
        logic [31:0] lv;
        logic [2:0]  ln;
        logic        lshort;
        logic [2:0]  llen;
        logic [3:0]  ilen;
        logic [4:0]  k;

        tshort = is_null || (tag_reg < 64'd31);
        groups = 4'd1;
        for (int i = 1; i < 10; i++)
        begin
            if ((tag_reg >> (7 * i)) != 64'd0)
            begin
                groups = 4'(i + 1);
            end
        end
        ilen = tshort ? 4'd1 : groups + 4'd1;

        un = 4'd1;
        for (int i = 1; i < 8; i++)
        begin
            if ((val_reg >> (8 * i)) != 64'd0)
            begin
                un = 4'(i + 1);
            end
        end
        lead = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (un == 4'(i + 1))
            begin
                lead = val_reg[8 * i + 7];
            end
        end

        sn = 4'd1;
        for (int i = 1; i < 8; i++)
        begin
            sh = 64'($signed(val_reg) >>> (8 * i - 1));
            if (sh != 64'd0 && sh != {64{1'b1}})
            begin
                sn = 4'(i + 1);
            end
        end

        cword = {8'h00, val_reg};
        case (cmd_reg)
            CMD_BOOL:
            begin
                clen  = 4'd1;
                cword = {64'd0, {8{val_reg[0]}}};
            end
            CMD_UINT: clen = un + {3'd0, lead};
            CMD_SINT: clen = sn;
            default:  clen = 4'd0;
        endcase

        lv = is_hdr ? clen_reg : {28'd0, clen};
        lshort = (lv < 32'd128);
        ln = 3'd1;
        for (int i = 1; i < 4; i++)
        begin
            if ((lv >> (8 * i)) != 32'd0)
            begin
                ln = 3'(i + 1);
            end
        end
        llen = lshort ? 3'd1 : ln + 3'd1;

        k = 5'(ilen) + 5'(llen) + 5'(clen);

        id_first_next  = {is_null ? 2'b00 : cls_reg,
                          is_hdr & cons_reg,
                          is_null ? 5'd5 : (tshort ? tag_reg[4:0] : 5'h1F)};
        id_groups_next = groups;
        id_len_next    = ilen;
        len_val_next   = lv;
        len_short_next = lshort;
        len_n_next     = ln;
        len_len_next   = llen;
        cont_len_next  = clen;
        cont_word_next = cword;
        add_next       = 33'(k) + (is_hdr ? {1'b0, clen_reg} : 33'd0);
    end

    always_ff @(posedge clk)
    begin
        if (word.size)
        begin
            id_first_reg  <= id_first_next;
            id_groups_reg <= id_groups_next;
            id_len_reg    <= id_len_next;
            len_val_reg   <= len_val_next;
            len_short_reg <= len_short_next;
            len_n_reg     <= len_n_next;
            len_len_reg   <= len_len_next;
            cont_len_reg  <= cont_len_next;
            cont_word_reg <= cont_word_next;
            add_reg       <= add_next;
        end
    end

    // Total after this encoding against the limit.
    assign fail = ({2'b00, written_reg} + {1'b0, add_reg}) > {2'b00, lim_reg};

    // Byte selection.
    assign tag_ext = {6'd0, tag_reg};
    always_comb
    begin
        for (int i = 0; i < 10; i++)
        begin
            grp[i] = tag_ext[7 * i +: 7];
        end
        for (int i = 0; i < 4; i++)
        begin
            lbyte[i] = len_val_reg[8 * i +: 8];
        end
        for (int i = 0; i < 9; i++)
        begin
            cbyte_w[i] = cont_word_reg[8 * i +: 8];
        end
    end

    assign gi = id_groups_reg - idx_reg;
    assign bi = len_n_reg[1:0] - idx_reg[1:0];
    assign ci = cont_len_reg - 4'd1 - idx_reg;

    always_comb
    begin
        sel_byte  = 8'h00;
        sel_last  = 1'b1;
        sel_err   = ERR_NONE;
        phase_len = 4'd1;
        case (word.src)
            SRC_IDENT:
            begin
                phase_len = id_len_reg;
                sel_last  = 1'b0;
                if (idx_reg == 4'd0)
                begin
                    sel_byte = id_first_reg;
                end
                else
                begin
                    sel_byte = {gi != 4'd0, grp[gi]};
                end
            end
            SRC_LEN:
            begin
                phase_len = {1'b0, len_len_reg};
                sel_last  = (idx_reg == {1'b0, len_len_reg - 3'd1}) &&
                            (cont_len_reg == 4'd0);
                if (idx_reg == 4'd0)
                begin
                    sel_byte = len_short_reg ? len_val_reg[7:0] : {5'b10000, len_n_reg};
                end
                else
                begin
                    sel_byte = lbyte[bi];
                end
            end
            SRC_CONT:
            begin
                phase_len = cont_len_reg;
                sel_last  = (idx_reg == cont_len_reg - 4'd1);
                sel_byte  = cbyte_w[ci];
            end
            SRC_ERR:
            begin
                sel_err = ERR_LIMIT;
            end
            SRC_CBYTE:
            begin
                if (pending_reg == 32'd0)
                begin
                    sel_err = ERR_UNEXPECTED;
                end
                else
                begin
                    sel_byte = cbyte_reg;
                end
            end
            default:
            begin
                sel_last = 1'b0;
            end
        endcase
    end

    assign out_load = word.emit && (!out_valid_reg || !out_stall);

    always_comb
    begin
        stat.accept   = accept;
        stat.cmd_byte = (cmd_reg == CMD_BYTE);
        stat.cmd_bad  = (cmd_reg > CMD_BYTE);
        stat.fail     = fail;
        stat.done     = out_load && (idx_reg == phase_len - 4'd1);
        stat.empty    = (cont_len_reg == 4'd0);
    end

    always_comb
    begin
        lim_next       = cfg_valid ? cfg_data : lim_reg;
        written_next   = written_reg;
        pending_next   = pending_reg;
        idx_next       = idx_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        error_next     = error_reg;

        if (word.check && !fail)
        begin
            written_next = written_reg + add_reg[31:0];
            if (is_hdr)
            begin
                pending_next = clen_reg;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            last_next      = sel_last;
            error_next     = sel_err;
            idx_next       = stat.done ? 4'd0 : idx_reg + 4'd1;
            if (word.src == SRC_CBYTE && pending_reg != 32'd0)
            begin
                pending_next = pending_reg - 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg       <= 32'hFFFF_FFFF;
            written_reg   <= 32'd0;
            pending_reg   <= 32'd0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lim_reg       <= lim_next;
            written_reg   <= written_next;
            pending_reg   <= pending_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

FILE: hw/rtl/der_tlv_scalar_encoder.sv
`timescale 1ns / 1ps

// DER TLV scalar encoder. Each input beat is one command; the block answers with
// the encoded bytes, one output beat per byte, and marks the final byte of the
// command with last. Boolean, unsigned, signed and null commands produce a whole
// identifier-length-contents encoding; a raw header command produces only the
// identifier and length, and the contents then follow as content-byte commands
// that are passed straight through. Every encoding is checked against the
// output limit register before anything is sent: if the running byte total
// would go over it, the command gives a single beat with error set to one and
// the total is left alone. A content byte with no contents outstanding gives a
// single beat with error two. Control is a ten-step microprogram held in a
// constant table: a step counter walks it and a plain datapath sizes the
// encoding, runs the limit check and selects each byte. Timing is set by that
// program and by the output register, which takes one byte a cycle unless the
// output stalls. A scalar walks idle, dispatch, size, check, identifier, length,
// skip and contents; a header ends at skip, a failed check jumps to the error
// step, a content byte goes from dispatch to the byte step, and unused codes
// return to idle from size and produce nothing. A new command is taken only when
// the previous one has been fully handed to the output register; output stalls
// simply hold the program in its current step. The configuration channel is
// always ready and should only be written while no command is in progress.

module der_tlv_scalar_encoder import dtse_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,

    // Command channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [1:0]  id_class,
    input  logic        constructed,
    input  logic [63:0] tag_number,
    input  logic [63:0] value,
    input  logic [31:0] content_length,
    input  logic [7:0]  content_byte,

    // Byte channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [1:0]  error,

    // Limit register write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    ucode_t  word;
    status_t stat;

    // The idle step is the only one that opens the command channel.
    assign in_stall  = !word.take;
    assign cfg_ready = 1'b1;

    dtse_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .word  (word)
    );

    dtse_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .word           (word),
        .stat           (stat),
        .in_valid       (in_valid),
        .command        (command),
        .id_class       (id_class),
        .constructed    (constructed),
        .tag_number     (tag_number),
        .value          (value),
        .content_length (content_length),
        .content_byte   (content_byte),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .out_byte       (out_byte),
        .last           (last),
        .error          (error)
    );

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the DER TLV scalar encoder.
//
// An initial block fills a queue of commands. A driver on the falling edge
// presents them one beat at a time. A monitor on the rising edge does two
// things. It feeds every accepted command through an encoder model of its
// own, which queues the bytes that command should produce. It also compares
// every accepted output beat with the oldest byte still due. Both sides idle
// and stall at random but for one phase run flat out. The limit register is
// rewritten only when the encoder has drained.

module testbench import dtse_pkg::*; ();

    // The two command codes that the encoder must ignore.
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // DER encoding constants.
    localparam int         SHORT_TAG_LIMIT = 31;
    localparam int         SHORT_LEN_LIMIT = 128;
    localparam logic [7:0] TAG_LONG_FORM   = 8'h1F;
    localparam logic [7:0] LEN_LONG_FORM   = 8'h80;
    localparam logic [7:0] GROUP_MORE      = 8'h80;
    localparam logic [7:0] NULL_IDENT      = 8'h05;
    localparam logic [7:0] BOOL_TRUE       = 8'hFF;
    localparam logic [7:0] BOOL_FALSE      = 8'h00;

    // Allowance in cycles for the encoder to settle once its last byte has gone.
    // It is meant to outlast even the longest full command, so this is ample.
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [2:0]  command;
        logic [1:0]  id_class;
        logic        constructed;
        logic [63:0] tag_number;
        logic [63:0] value;
        logic [31:0] content_length;
        logic [7:0]  content_byte;
    } der_cmd_t;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
        logic [1:0] err;
    } der_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    der_cmd_t    drv_cmd = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last;
    logic [1:0]  error;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // Commands waiting to be driven, and the bytes the encoder still owes.
    der_cmd_t    pending_cmds [$];
    der_beat_t   bytes_due [$];

    // Model copy of the encoder state and of its limit register.
    logic [31:0] limit_value = 32'hFFFF_FFFF;
    logic [31:0] written_total = '0;
    logic [31:0] contents_left = '0;

    int          commands_queued = 0;
    int          commands_taken = 0;
    int          mismatch_count = 0;
    bit          cmd_fire = 1'b0;
    int          idle_left = 0;
    int          stall_left = 0;
    bit          sender_idle_on = 1'b1;
    bit          receiver_idle_on = 1'b1;

    der_tlv_scalar_encoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (drv_cmd.command),
        .id_class       (drv_cmd.id_class),
        .constructed    (drv_cmd.constructed),
        .tag_number     (drv_cmd.tag_number),
        .value          (drv_cmd.value),
        .content_length (drv_cmd.content_length),
        .content_byte   (drv_cmd.content_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last           (last),
        .error          (error),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Length of an idle run: mostly nothing, often a few cycles, now and then a long one.
    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        else if (pick < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(12, 40);
    endfunction

    // Wide random value. One time in four it is left unshifted, so that the upper bits
    // are often set; otherwise it is shifted down to spread the magnitudes.
    function automatic logic [63:0] wide_random();
        logic [63:0] r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            return r;
        return r >> $urandom_range(0, 63);
    endfunction

    // Works out the bytes that one accepted command should produce. It updates the model
    // state just as the encoder does.
    function automatic void encode_command(input der_cmd_t c);
        logic [7:0]  tlv [$];
        logic [7:0]  body [$];
        logic [7:0]  octet [8];
        logic [7:0]  lead;
        logic [63:0] chunk;
        logic [63:0] total;
        logic [31:0] len;
        int          nbytes;
        int          top;
        int          groups;
        int          i;

        // A content byte passes straight through while contents are outstanding.
        // Otherwise it is reported as unexpected. It is never counted against the
        // limit again.
        if (c.command == CMD_BYTE)
        begin
            if (contents_left == 0)
                bytes_due.insert(bytes_due.size(), {8'h00, 1'b1, ERR_UNEXPECTED});
            else
            begin
                contents_left = contents_left - 1;
                bytes_due.insert(bytes_due.size(), {c.content_byte, 1'b1, ERR_NONE});
            end
            return;
        end
        if (c.command > CMD_BYTE)
            return;

        case (c.command)
            CMD_BOOL:
                body.insert(body.size(), c.value[0] ? BOOL_TRUE : BOOL_FALSE);
            CMD_UINT:
            begin
                // Minimal big-endian bytes. Add a zero in front if the top bit would
                // read as a sign.
                nbytes = 1;
                while (nbytes < 8 && (c.value >> (8 * nbytes)) != 0)
                    nbytes++;
                if (c.value[8 * nbytes - 1])
                    body.insert(body.size(), 8'h00);
                for (i = nbytes - 1; i >= 0; i--)
                    body.insert(body.size(), c.value[8 * i +: 8]);
            end
            CMD_SINT:
            begin
                // Drop leading bytes that only repeat the sign of the byte after them.
                for (i = 0; i < 8; i++)
                    octet[i] = c.value[8 * (7 - i) +: 8];
                top = 0;
                while (top < 7 &&
                       ((octet[top] == 8'h00 && !octet[top + 1][7]) ||
                        (octet[top] == 8'hFF && octet[top + 1][7])))
                    top++;
                for (i = top; i < 8; i++)
                    body.insert(body.size(), octet[i]);
            end
            default:
            begin
            end
        endcase

        // Identifier. Null is always universal tag five. Only the raw header carries
        // the constructed bit.
        lead = {c.id_class, (c.command == CMD_HDR && c.constructed) ? 1'b1 : 1'b0, 5'b0};
        if (c.command == CMD_NULL)
            tlv.insert(tlv.size(), NULL_IDENT);
        else if (c.tag_number < SHORT_TAG_LIMIT)
            tlv.insert(tlv.size(), lead | {3'b000, c.tag_number[4:0]});
        else
        begin
            tlv.insert(tlv.size(), lead | TAG_LONG_FORM);
            groups = 1;
            while (groups < 10 && (c.tag_number >> (7 * groups)) != 0)
                groups++;
            for (i = groups; i > 0; i--)
            begin
                chunk = c.tag_number >> (7 * (i - 1));
                tlv.insert(tlv.size(), {1'b0, chunk[6:0]} | ((i > 1) ? GROUP_MORE : 8'h00));
            end
        end

        // Length, short form or 0x80 plus the byte count.
        if (c.command == CMD_NULL)
            len = '0;
        else if (c.command == CMD_HDR)
            len = c.content_length;
        else
            len = 32'(body.size());
        if (len < SHORT_LEN_LIMIT)
            tlv.insert(tlv.size(), len[7:0]);
        else
        begin
            nbytes = 0;
            chunk = {32'd0, len};
            while (chunk != 0)
            begin
                nbytes++;
                chunk = chunk >> 8;
            end
            tlv.insert(tlv.size(), LEN_LONG_FORM | nbytes[7:0]);
            for (i = nbytes; i > 0; i--)
            begin
                chunk = {32'd0, len} >> (8 * (i - 1));
                tlv.insert(tlv.size(), chunk[7:0]);
            end
        end
        for (i = 0; i < body.size(); i++)
            tlv.insert(tlv.size(), body[i]);

        // A raw header reserves room for its contents up front. The check is arranged
        // so that it cannot wrap.
        total = 64'(tlv.size());
        if (c.command == CMD_HDR)
            total = total + {32'd0, c.content_length};
        if (total > {32'd0, limit_value} ||
            {32'd0, written_total} > {32'd0, limit_value} - total)
        begin
            bytes_due.insert(bytes_due.size(), {8'h00, 1'b1, ERR_LIMIT});
            return;
        end

        written_total = written_total + total[31:0];
        if (c.command == CMD_HDR)
            contents_left = c.content_length;
        for (i = 0; i < tlv.size(); i++)
            bytes_due.insert(bytes_due.size(),
                             {tlv[i], (i == tlv.size() - 1) ? 1'b1 : 1'b0, ERR_NONE});
    endfunction

    function automatic void push_cmd(input der_cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
        commands_queued++;
    endfunction

    function automatic void queue_item(input logic [2:0] op, input logic [1:0] cls,
                                       input logic cons, input logic [63:0] tag,
                                       input logic [63:0] val, input logic [31:0] len,
                                       input logic [7:0] cbyte);
        push_cmd({op, cls, cons, tag, val, len, cbyte});
    endfunction

    // A command with every field random. Fields that the command ignores still vary.
    function automatic der_cmd_t random_cmd(input logic [2:0] op);
        der_cmd_t c;
        c.command = op;
        c.id_class = 2'($urandom_range(0, 3));
        c.constructed = 1'($urandom_range(0, 1));
        c.tag_number = $urandom_range(0, 1) ? {32'd0, $urandom_range(0, 30)} : wide_random();
        c.value = wide_random();
        if ($urandom_range(0, 1))
            c.value = ~c.value;
        c.content_length = $urandom;
        c.content_byte = 8'($urandom);
        return c;
    endfunction

    // Queues one random sequence and returns how many of its commands count toward
    // the total. Most sequences are whole scalars or headers with their contents.
    // The rest are truncated contents, stray content bytes and unused codes.
    // Headers with a huge length are only used while the limit is tight, where they
    // must fail.
    function automatic int queue_random_sequence(input bit allow_huge);
        der_cmd_t    hdr;
        logic [31:0] hlen;
        int          pick;
        int          sent;
        int          i;

        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            push_cmd(random_cmd(3'($urandom_range(CMD_BOOL, CMD_NULL))));
            return 1;
        end
        if (pick < 90)
        begin
            hdr = random_cmd(CMD_HDR);
            if (allow_huge && $urandom_range(0, 3) == 0)
            begin
                hlen = $urandom;
                sent = $urandom_range(0, 2);
            end
            else
            begin
                hlen = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 133)
                                                  : $urandom_range(0, 6);
                if (pick < 80 || hlen == 0)
                    sent = hlen;
                else
                    sent = $urandom_range(0, hlen - 1);
            end
            hdr.content_length = hlen;
            push_cmd(hdr);
            for (i = 0; i < sent; i++)
                push_cmd(random_cmd(CMD_BYTE));
            return 1 + sent;
        end
        if (pick < 96)
        begin
            push_cmd(random_cmd(CMD_BYTE));
            return 1;
        end
        push_cmd(random_cmd($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI));
        return 0;
    endfunction

    // Waits until every queued command has been taken and every byte it caused
    // has arrived. Then it gives the encoder time to settle. Unused codes produce
    // nothing, so the settling time matters.
    task automatic wait_until_drained();
        while (commands_taken != commands_queued || bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [31:0] new_limit);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = new_limit;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_value = new_limit;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Command driver. A beat stays put until it is taken. After each beat a random
    // gap may follow.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || cmd_fire))
        begin
            if (idle_left != 0)
            begin
                idle_left <= idle_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                drv_cmd <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                idle_left <= sender_idle_on ? idle_length() : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output stall generator. Runs of stall never abut; stall is dropped whenever a new run length is drawn.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left <= receiver_idle_on ? idle_length() : 0;
            out_stall <= 1'b0;
        end
    end

    // Monitor. It models each accepted command and checks each accepted output beat
    // against the oldest byte still due.
    always @(posedge clk)
    begin
        cmd_fire = rst_n && in_valid && !in_stall;
        if (cmd_fire)
        begin
            encode_command(drv_cmd);
            commands_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (bytes_due.size() == 0)
            begin
                $display("%0t: unexpected beat, got byte %02h last %b error %0d",
                         $time, out_byte, last, error);
                mismatch_count++;
            end
            else if (bytes_due[0] != {out_byte, last, error})
            begin
                $display("%0t: beat mismatch, expected byte %02h last %b error %0d,",
                         $time, bytes_due[0].octet, bytes_due[0].last, bytes_due[0].err,
                         " got byte %02h last %b error %0d", out_byte, last, error);
                mismatch_count++;
                void'(bytes_due.pop_front());
            end
            else
                void'(bytes_due.pop_front());
        end
    end

    // Overall time limit. Even the slowest legal run, with every beat meeting a long
    // stall, finishes well inside it.
    initial
    begin
        #12_000_000;
        $display("FAIL der_tlv_scalar_encoder");
        $finish;
    end

    initial
    begin
        int count;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The limit is still at its reset value.
        // Booleans. The constructed bit must be cleared on a scalar.
        queue_item(CMD_BOOL, 2'd0, 1'b0, 64'd1, 64'd0, 32'd0, 8'h00);
        queue_item(CMD_BOOL, 2'd3, 1'b1, 64'd30, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 8'hFF);
        // Unsigned integers: zero, the largest single byte, one that needs a
        // leading zero, and the worst case of 21 bytes.
        queue_item(CMD_UINT, 2'd0, 1'b0, 64'd2, 64'd0, 32'd0, 8'h00);
        queue_item(CMD_UINT, 2'd1, 1'b0, 64'd2, 64'h7F, 32'd0, 8'h00);
        queue_item(CMD_UINT, 2'd1, 1'b0, 64'd2, 64'h80, 32'd0, 8'h00);
        queue_item(CMD_UINT, 2'd2, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   32'hFFFF_FFFF, 8'h00);
        // Signed integers around the points where the sign byte is kept.
        queue_item(CMD_SINT, 2'd0, 1'b0, 64'd2, 64'd0, 32'd0, 8'h00);
        queue_item(CMD_SINT, 2'd0, 1'b0, 64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 8'h00);
        queue_item(CMD_SINT, 2'd0, 1'b0, 64'd2, 64'h80, 32'd0, 8'h00);
        queue_item(CMD_SINT, 2'd0, 1'b0, 64'd2, 64'hFFFF_FFFF_FFFF_FF7F, 32'd0, 8'h00);
        queue_item(CMD_SINT, 2'd1, 1'b0, 64'd2, 64'h8000_0000_0000_0000, 32'd0, 8'h00);
        queue_item(CMD_SINT, 2'd1, 1'b0, 64'd31, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 8'h00);
        // Null ignores its class and tag.
        queue_item(CMD_NULL, 2'd3, 1'b1, 64'd999, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5, 8'h00);
        // Tag numbers at the edges of the base-128 groups.
        queue_item(CMD_BOOL, 2'd2, 1'b0, 64'd127, 64'd1, 32'd0, 8'h00);
        queue_item(CMD_BOOL, 2'd2, 1'b0, 64'd128, 64'd0, 32'd0, 8'h00);
        // Constructed header with its contents, then a stray content byte.
        queue_item(CMD_HDR, 2'd1, 1'b1, 64'd16, 64'd0, 32'd3, 8'h00);
        queue_item(CMD_BYTE, 2'd0, 1'b0, 64'd0, 64'd0, 32'd0, 8'h00);
        queue_item(CMD_BYTE, 2'd0, 1'b0, 64'd0, 64'd0, 32'd0, 8'hFF);
        queue_item(CMD_BYTE, 2'd0, 1'b0, 64'd0, 64'd0, 32'd0, 8'h5A);
        queue_item(CMD_BYTE, 2'd0, 1'b0, 64'd0, 64'd0, 32'd0, 8'h3C);
        // Long-form length, cut short. A new header replaces what is outstanding.
        queue_item(CMD_HDR, 2'd0, 1'b0, 64'd4, 64'd0, 32'd130, 8'h00);
        queue_item(CMD_BYTE, 2'd0, 1'b0, 64'd0, 64'd0, 32'd0, 8'h11);
        queue_item(CMD_BYTE, 2'd0, 1'b0, 64'd0, 64'd0, 32'd0, 8'h22);
        queue_item(CMD_HDR, 2'd3, 1'b0, 64'd40, 64'd0, 32'd1, 8'h00);
        queue_item(CMD_BYTE, 2'd0, 1'b0, 64'd0, 64'd0, 32'd0, 8'hA5);
        // A header whose contents could never fit, even against the largest limit.
        queue_item(CMD_HDR, 2'd0, 1'b1, 64'd5, 64'd0, 32'hFFFF_FFFF, 8'h00);
        // Unused codes give no beats at all.
        queue_item(CMD_SPARE_LO, 2'd1, 1'b1, 64'd7, 64'd1, 32'd1, 8'h01);
        queue_item(CMD_SPARE_HI, 2'd2, 1'b0, 64'd7, 64'd1, 32'd1, 8'h01);
        wait_until_drained();

        // Largest limit, written explicitly. This is the bulk of the random traffic.
        write_limit(32'hFFFF_FFFF);
        count = 0;
        while (count < 100)
            count += queue_random_sequence(1'b0);
        wait_until_drained();

        // A zero limit, now below the running total: every encoding must fail.
        write_limit(32'd0);
        count = 0;
        while (count < 16)
            count += queue_random_sequence(1'b1);
        wait_until_drained();

        // A little headroom above the running total, so that some encodings fit and
        // then the limit is hit. Both sides run flat out through this phase.
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        write_limit(written_total + $urandom_range(60, 200));
        count = 0;
        while (count < 50)
            count += queue_random_sequence(1'b1);
        wait_until_drained();

        // Back to the largest limit, with idling on both sides again.
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        write_limit(32'hFFFF_FFFF);
        count = 0;
        while (count < 64)
            count += queue_random_sequence(1'b0);
        wait_until_drained();

        if (mismatch_count == 0)
            $display("PASS der_tlv_scalar_encoder");
        else
            $display("FAIL der_tlv_scalar_encoder");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dtse_pkg.sv
hw/rtl/dtse_sequencer.sv
hw/rtl/dtse_datapath.sv
hw/rtl/der_tlv_scalar_encoder.sv
bench/testbench.sv
